// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while reset is low.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- rtl/dvsew_pkg.sv -----
// Types and constants of the DVS event word encoder.
// Depends on nothing; imported by the top level and its checker.
package dvsew_pkg;

   // One event as it arrives on the request stream, highest field first
   typedef struct packed {
      logic [9:0]  misc_data;
      logic        polarity;
      logic [63:0] event_time;
      logic [15:0] y_stream_value;
      logic [15:0] x_stream_value;
   } event_type;

   // Per-event flags carried on every word of a run
   typedef struct packed {
      logic [11:0] wrap_delta;
      logic        time_not_increasing;
      logic        row_changed;
      logic        time_changed;
   } flags_type;

   localparam int EVENT_W    = $bits(event_type);
   localparam int REQ_DATA_W = ((EVENT_W + 7) / 8) * 8;
   localparam int WORD_W     = 16;
   localparam int WRAP_W     = 12;
   localparam int RSP_DATA_W = (((WORD_W + WRAP_W) + 7) / 8) * 8;
   localparam int RSP_USER_W = 3;
   localparam int RUN_MAX    = 4;
   localparam int RUN_CNT_W  = 3;
   localparam int TS_LOW_W   = 15;

   // Word tags and fixed patterns
   localparam logic [3:0]        TAG_ROW   = 4'h1;
   localparam logic [3:0]        TAG_COL   = 4'h2;
   localparam logic [3:0]        TAG_WRAP  = 4'h7;
   localparam logic              TAG_TIME  = 1'b1;
   localparam logic [5:0]        MISC_HEAD = 6'b011001;

   // Run lengths
   localparam logic [RUN_CNT_W-1:0] RUN_FULL = 3'd4;
   localparam logic [RUN_CNT_W-1:0] RUN_ROW  = 3'd3;
   localparam logic [RUN_CNT_W-1:0] RUN_MIN  = 3'd2;

endpackage

// ----- rtl/dvs_event_word_encoder.sv -----
// An accepted event waits in the event register until the word register is free, then
// loads there as a run of 2 to 4 words. The single result channel carries one 16-bit
// word a cycle while rsp_tready is high and sets the throughput; an input register lets the
// next event enter while the current run drains. Reset (synchronous, active high) empties
// both stages and clears the previous timestamp and row to zero.
// Top level: event register, encoder logic and a shifting word register; uses dvsew_pkg.
module dvs_event_word_encoder
   import dvsew_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // x_stream_value, y_stream_value, event_time, polarity, misc_data, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // word, wrap_delta, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // time_changed, row_changed, time_not_increasing
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   logic                  ev_valid_ff;
   event_type             ev_ff;
   logic [RUN_CNT_W-1:0]  run_cnt_ff, run_cnt_in;
   logic [WORD_W-1:0]     run_word_ff [RUN_MAX];
   logic [WORD_W-1:0]     run_word_in [RUN_MAX];
   flags_type             run_flags_ff, run_flags_in;
   logic [63:0]           prev_time_ff;
   logic [15:0]           prev_row_ff;

   logic                  rsp_take, req_take, run_free, ev_move;
   flags_type             flags;
   logic                  wrap_up;
   logic [WORD_W-1:0]     ts_word, row_word, col_word, misc_word;
   logic [WORD_W-1:0]     enc_word [RUN_MAX];
   logic [RUN_CNT_W-1:0]  enc_cnt;

   // Handshakes
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign run_free   = (run_cnt_ff == '0) || (rsp_take && run_cnt_ff == RUN_CNT_W'(1));
   assign ev_move    = ev_valid_ff && run_free;
   assign req_tready = !ev_valid_ff || ev_move;

   // Hold the incoming event
   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else if (req_tready) begin
         ev_valid_ff <= req_tvalid;
      end
      if (req_take) begin
         ev_ff <= event_type'(req_tdata[EVENT_W-1:0]);
      end
   end

   // Compare with the previous event and build the words
   always_comb begin
      wrap_up                   = ev_ff.event_time[63:TS_LOW_W] > prev_time_ff[63:TS_LOW_W];
      flags.time_changed        = ev_ff.event_time != prev_time_ff;
      flags.time_not_increasing = ev_ff.event_time < prev_time_ff;
      flags.row_changed         = !flags.time_changed
                                  && (ev_ff.x_stream_value != prev_row_ff);
      flags.wrap_delta          = '0;
      if (flags.time_changed && wrap_up) begin
         flags.wrap_delta = ev_ff.event_time[TS_LOW_W+WRAP_W-1:TS_LOW_W]
                            - prev_time_ff[TS_LOW_W+WRAP_W-1:TS_LOW_W];
      end

      if (wrap_up) begin
         ts_word = {TAG_WRAP, flags.wrap_delta};
      end else begin
         ts_word = {TAG_TIME, ev_ff.event_time[TS_LOW_W-1:0]};
      end
      row_word  = {TAG_ROW, ev_ff.x_stream_value[11:0]};
      col_word  = {TAG_COL + {3'b000, ev_ff.polarity}, ev_ff.y_stream_value[11:0]};
      misc_word = {MISC_HEAD, ev_ff.misc_data};

      // Order the run: timestamp, row, column, misc
      if (flags.time_changed) begin
         enc_word[0] = ts_word;
         enc_word[1] = row_word;
         enc_word[2] = col_word;
         enc_word[3] = misc_word;
         enc_cnt     = RUN_FULL;
      end else if (flags.row_changed) begin
         enc_word[0] = row_word;
         enc_word[1] = col_word;
         enc_word[2] = misc_word;
         enc_word[3] = misc_word;
         enc_cnt     = RUN_ROW;
      end else begin
         enc_word[0] = col_word;
         enc_word[1] = misc_word;
         enc_word[2] = misc_word;
         enc_word[3] = misc_word;
         enc_cnt     = RUN_MIN;
      end
   end

   // Load a new run or advance the current one
   always_comb begin
      run_cnt_in   = run_cnt_ff;
      run_flags_in = run_flags_ff;
      run_word_in  = run_word_ff;
      if (ev_move) begin
         run_cnt_in   = enc_cnt;
         run_flags_in = flags;
         run_word_in  = enc_word;
      end else if (rsp_take) begin
         run_cnt_in = run_cnt_ff - RUN_CNT_W'(1);
         for (int i = 0; i < RUN_MAX - 1; i++) begin
            run_word_in[i] = run_word_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff   <= '0;
         prev_time_ff <= '0;
         prev_row_ff  <= '0;
      end else begin
         run_cnt_ff <= run_cnt_in;
         if (ev_move) begin
            prev_time_ff <= ev_ff.event_time;
            prev_row_ff  <= ev_ff.x_stream_value;
         end
      end
      run_flags_ff <= run_flags_in;
      run_word_ff  <= run_word_in;
   end

   // Drive the result stream from the head of the run
   assign rsp_tvalid = run_cnt_ff != '0;
   assign rsp_tlast  = run_cnt_ff == RUN_CNT_W'(1);
   assign rsp_tdata  = {(RSP_DATA_W - WORD_W - WRAP_W)'(0), run_flags_ff.wrap_delta,
                        run_word_ff[0]};
   assign rsp_tuser  = {run_flags_ff.time_not_increasing, run_flags_ff.row_changed,
                        run_flags_ff.time_changed};

endmodule

// ----- rtl/dvsew_checker.sv -----
// Port-level checks of the DVS event word encoder, bound to the top level.
// Depends on dvsew_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dvsew_checker
   import dvsew_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast
);

   // Nothing leaves right after reset
   `ASSERT_CLK_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid)

   // A stalled word holds
   `ASSERT_CLK(a_stall_holds, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))

   // A run continues without a gap and keeps its flags
   `ASSERT_CLK(a_run_flags_hold, clock, reset,
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && $stable(rsp_tuser)
         && (rsp_tdata[27:16] == $past(rsp_tdata[27:16]))))

   // Row change is flagged only with an unchanged timestamp, a time decrease only with a changed one
   `ASSERT_CLK(a_flags_consistent, clock, reset,
      rsp_tvalid |-> (!(rsp_tuser[0] && rsp_tuser[1]) && (!rsp_tuser[2] || rsp_tuser[0])))

endmodule

bind dvs_event_word_encoder dvsew_checker u_dvsew_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for dvs_event_word_encoder: random and directed events in,
// encoded 16-bit words out, each compared against an in-bench encoder model.
// Depends on dvsew_pkg and the dvs_event_word_encoder top level.
module testbench;
   import dvsew_pkg::*;

   // One expected or observed output word with its per-event flags
   typedef struct {
      logic [15:0] word;
      logic        last_word;
      logic        time_changed;
      logic        row_changed;
      logic        time_not_increasing;
      logic [11:0] wrap_delta;
   } encoded_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // Events waiting to be driven and words waiting to be seen
   event_type        event_queue[$];
   encoded_word_type expected_words[$];

   // Encoder model state: timestamp and full row of the last accepted event
   logic [63:0] last_time;
   logic [15:0] last_row;

   // Generator's view of the last queued event, used to shape the next one
   logic [63:0] gen_time = '0;
   logic [15:0] gen_row = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int events_accepted = 0;
   int words_checked = 0;
   int directed_count = 0;

   dvs_event_word_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Work out the word run of one accepted event and update the model state
   function automatic void encode_event(input event_type ev);
      encoded_word_type w;
      logic [48:0]      upper_new;
      logic [48:0]      upper_old;
      upper_new = ev.event_time[63:15];
      upper_old = last_time[63:15];
      w.last_word = 1'b0;
      w.time_changed = (ev.event_time != last_time);
      w.row_changed = 1'b0;
      w.time_not_increasing = 1'b0;
      w.wrap_delta = '0;
      if (w.time_changed) begin
         w.time_not_increasing = (ev.event_time < last_time);
         w.word = {TAG_TIME, ev.event_time[14:0]};
         // upper part rose: send the truncated increase as a wrap word instead
         if (upper_new > upper_old) begin
            w.wrap_delta = 12'(upper_new - upper_old);
            w.word = {TAG_WRAP, w.wrap_delta};
         end
         expected_words.push_back(w);
         w.word = {TAG_ROW, ev.x_stream_value[11:0]};
         expected_words.push_back(w);
      end else if (ev.x_stream_value != last_row) begin
         w.row_changed = 1'b1;
         w.word = {TAG_ROW, ev.x_stream_value[11:0]};
         expected_words.push_back(w);
      end
      w.word = {4'(TAG_COL + ev.polarity), ev.y_stream_value[11:0]};
      expected_words.push_back(w);
      w.word = {MISC_HEAD, ev.misc_data};
      w.last_word = 1'b1;
      expected_words.push_back(w);
      last_time = ev.event_time;
      last_row = ev.x_stream_value;
   endfunction

   // Queue one event and track it for shaping the next
   function automatic void add_event(input logic [15:0] x, input logic [15:0] y,
                                     input logic [63:0] t, input logic pol,
                                     input logic [9:0] misc);
      event_type ev;
      ev.x_stream_value = x;
      ev.y_stream_value = y;
      ev.event_time = t;
      ev.polarity = pol;
      ev.misc_data = misc;
      event_queue.push_back(ev);
      gen_time = t;
      gen_row = x;
   endfunction

   // Queue a random event, mostly near the previous timestamp and row
   function automatic void add_random_event();
      logic [63:0] t;
      logic [15:0] x;
      int          row_pick;
      row_pick = $urandom_range(3);
      case ($urandom_range(9))
         0, 1, 2: t = gen_time;
         3, 4:    t = gen_time + 64'($urandom_range(1, 100));
         5:       t = gen_time + (64'($urandom_range(1, 5)) << 15)
                      + 64'($urandom_range(0, 32767));
         6:       t = gen_time + (64'($urandom_range(1, 8191)) << 15);
         7:       t = gen_time - 64'($urandom_range(1, 70000));
         8:       t = {gen_time[63:15], 15'($urandom)};
         default: t = {$urandom, $urandom};
      endcase
      if (row_pick < 2)
         x = gen_row;
      else if (row_pick == 2)
         x = 16'($urandom);
      else
         x = {gen_row[15:12] ^ 4'($urandom_range(1, 15)), gen_row[11:0]};
      add_event(x, 16'($urandom), t, 1'($urandom), 10'($urandom));
   endfunction

   // Driver: present queued events, predict each one as it is transferred
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         last_time = '0;
         last_row = '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            encode_event(event_type'(req_tdata[EVENT_W-1:0]));
            events_accepted++;
         end
         if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= REQ_DATA_W'(event_queue.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: check every transferred word against the oldest expectation
   always @(posedge clock) begin
      encoded_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               report_mismatch("word with none pending", 64'(rsp_tdata[15:0]), '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[15:0] !== want.word)
                  report_mismatch("word", 64'(rsp_tdata[15:0]), 64'(want.word));
               if (rsp_tlast !== want.last_word)
                  report_mismatch("last_word", 64'(rsp_tlast), 64'(want.last_word));
               if (rsp_tuser[0] !== want.time_changed)
                  report_mismatch("time_changed", 64'(rsp_tuser[0]),
                                  64'(want.time_changed));
               if (rsp_tuser[1] !== want.row_changed)
                  report_mismatch("row_changed", 64'(rsp_tuser[1]), 64'(want.row_changed));
               if (rsp_tuser[2] !== want.time_not_increasing)
                  report_mismatch("time_not_increasing", 64'(rsp_tuser[2]),
                                  64'(want.time_not_increasing));
               if (rsp_tdata[27:16] !== want.wrap_delta)
                  report_mismatch("wrap_delta", 64'(rsp_tdata[27:16]),
                                  64'(want.wrap_delta));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Hold until every queued event is transferred and every word has come
   task automatic wait_drained();
      do
         @(posedge clock);
      while (event_queue.size() != 0 || req_tvalid || expected_words.size() != 0);
   endtask

   // Run one phase of random events under the given idle rates
   task automatic run_phase(input int send_pct, input int recv_pct, input int count);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) add_random_event();
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed events: reset match, row-only changes, wrap extremes, decreases
      add_event(16'h0000, 16'h0000, 64'h0, 1'b0, 10'h000);
      add_event(16'h1000, 16'h0123, 64'h0, 1'b1, 10'h155);
      add_event(16'hFFFF, 16'hFFFF, 64'h0, 1'b1, 10'h3FF);
      add_event(16'hFFFF, 16'hF000, 64'h0, 1'b0, 10'h2AA);
      add_event(16'h0FFF, 16'h0FFF, 64'h5, 1'b0, 10'h000);
      add_event(16'h0FFF, 16'h0001, 64'h7FFF, 1'b1, 10'h001);
      add_event(16'h0ABC, 16'h0DEF, 64'h8000, 1'b0, 10'h200);
      add_event(16'h0ABC, 16'h0DEF, 64'h8000 + (64'd4095 << 15), 1'b1, 10'h100);
      add_event(16'h0ABC, 16'h0DEF, gen_time + (64'd4096 << 15), 1'b0, 10'h0F0);
      add_event(16'h0ABD, 16'h0DEF, gen_time + (64'd4097 << 15), 1'b1, 10'h00F);
      add_event(16'h0ABD, 16'h0777, gen_time - 64'd3, 1'b0, 10'h3C3);
      add_event(16'h0ABD, 16'h0777, gen_time - (64'd1 << 20), 1'b1, 10'h0C3);
      add_event(16'hA5A5, 16'h5A5A, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 10'h1E1);
      add_event(16'h5A5A, 16'hA5A5, 64'h0, 1'b1, 10'h21E);
      add_event(16'h5A5A, 16'hA5A5, 64'h0, 1'b0, 10'h0);
      add_event(16'h0000, 16'h0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 10'h0);
      add_event(16'hFFFF, 16'hFFFF, 64'h5555_5555_5555_5555, 1'b1, 10'h3FF);
      directed_count = event_queue.size();
      wait_drained();

      run_phase(0, 0, 80);
      run_phase(54, 0, 80);
      run_phase(0, 54, 80);
      run_phase(15, 15, 80);

      // Let any stray words surface before the verdict
      repeat (12) @(posedge clock);
      $display("Sent %0d events (%0d directed) and checked %0d words", events_accepted,
               directed_count, words_checked);
      $display("Phases: full rate, sender gaps, receiver stalls, both mixed");
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Stop a hung run
   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
